@@ sv/qpsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsd_pkg
// shared types, constants and byte helpers for the query pair splitter
// ----------------------------------------------------------------------------
package qpsd_pkg;

    // key store sizing
    localparam int KEY_MAX     = 64;
    localparam int KEY_DEPTH   = KEY_MAX - 1;
    localparam int KEY_IDX_W   = $clog2(KEY_DEPTH);
    localparam int KEY_CNT_W   = $clog2(KEY_MAX);
    localparam int KEY_CAP_W   = 7;

    // value cut sizing
    localparam int VALUE_LIMIT = 4096;
    localparam int VALUE_CAP_W = 13;
    localparam int VALUE_CNT_W = 12;

    // command queue between front and back
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    // configuration register indexes
    localparam logic REG_KEY_CAP   = 1'b0;
    localparam logic REG_VALUE_CAP = 1'b1;

    // result part codes
    localparam logic [1:0] PART_KEY   = 2'd0;
    localparam logic [1:0] PART_VALUE = 2'd1;
    localparam logic [1:0] PART_END   = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_HIGH    = 8'h80;

    typedef struct packed {
        logic [7:0] query_byte;
        logic       end_of_query;
    } query_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] part;
        logic       separator_found;
        logic       last_of_run;
    } result_t;

    // key store write port, front to back
    typedef struct packed {
        logic                 en;
        logic [KEY_IDX_W-1:0] addr;
        logic [7:0]           data;
    } key_wr_t;

    // one command: key replay length, up to two value bytes, optional end
    typedef struct packed {
        logic [KEY_CNT_W-1:0] key_len;
        logic [1:0][7:0]      vbyte;
        logic [1:0]           vcount;
        logic                 is_end;
        logic                 sep;
    } cmd_t;

    // hex digit value, no validation
    function automatic logic [7:0] digit(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CH_HIGH)
            d = c - 8'd48;
        else if (c >= CH_LOWER_A)
            d = c - 8'd87;
        else if (c >= CH_UPPER_A)
            d = c - 8'd55;
        else
            d = c - 8'd48;
        return d;
    endfunction

    function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] dh;
        dh = digit(hi);
        return {dh[3:0], 4'd0} | digit(lo);
    endfunction

    function automatic logic [7:0] plain(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

@@ sv/query_pair_split_percent_decode_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_pair_split_percent_decode_top
// splits the first key=value pair off a query string and percent-decodes
// the value, one query byte per transaction in, one result per transaction out
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload                 direction
//  query     query_valid / query_stall  qpsd_pkg::query_t       into block
//  result    result_valid / result_stall qpsd_pkg::result_t     out of block
//  config    wr_en                      wr_index, wr_data       into block
//
//  the parser takes one query byte per cycle while the command queue has room,
//  key bytes apart while a replay is pending; the sequencer sends one result
//  per cycle while result_stall is low; a '=' with key bytes starts a replay
//  from the key store, and key bytes of the next query wait until it is done
//  rst_n is asynchronous; no clearing pass, the key store is only read where
//  written
//  result_stall holds the output register, the queue absorbs up to four
//  commands before query_stall rises
// ----------------------------------------------------------------------------
module query_pair_split_percent_decode_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // query byte transactions
    input  logic                             query_valid,
    output logic                             query_stall,
    input  qpsd_pkg::query_t                 query_data,
    // result transactions
    output logic                             result_valid,
    input  logic                             result_stall,
    output qpsd_pkg::result_t                result_data,
    // configuration writes, only while idle
    input  logic                             wr_en,
    input  logic                             wr_index,
    input  logic [qpsd_pkg::VALUE_CAP_W-1:0] wr_data
);

    // key store writes from the parser into the sequencer's memory
    qpsd_pkg::key_wr_t key_wr;

    // command queue signals
    logic              cmd_push;
    qpsd_pkg::cmd_t    cmd_data;
    logic              cmd_full;
    logic              cmd_pop;
    qpsd_pkg::cmd_t    cmd_head;
    logic              cmd_empty;

    // sequencer has read the last key byte, store may be refilled
    logic              replay_done;

    // front: parser, capacities, escape state, key buffering
    qpsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_stall (query_stall),
        .query_data  (query_data),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .key_wr      (key_wr),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_data),
        .replay_done (replay_done)
    );

    // queue decouples parser stalls from result stalls
    qpsd_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd_data),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .head     (cmd_head),
        .empty    (cmd_empty)
    );

    // back: expands each command into key, value and end results
    qpsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_wr       (key_wr),
        .cmd_empty    (cmd_empty),
        .cmd_head     (cmd_head),
        .cmd_pop      (cmd_pop),
        .replay_done  (replay_done),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

@@ sv/qpsd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsd_front
// byte parser: key buffering, value decode, command generation
// ----------------------------------------------------------------------------
module qpsd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            query_valid,
    output logic                            query_stall,
    input  qpsd_pkg::query_t                query_data,
    input  logic                            wr_en,
    input  logic                            wr_index,
    input  logic [qpsd_pkg::VALUE_CAP_W-1:0] wr_data,
    output qpsd_pkg::key_wr_t               key_wr,
    input  logic                            cmd_full,
    output logic                            cmd_push,
    output qpsd_pkg::cmd_t                  cmd_data,
    input  logic                            replay_done
);

    typedef enum logic [3:0] {
        PH_KEY        = 4'b0001,
        PH_VALUE      = 4'b0010,
        PH_DONE_SEP   = 4'b0100,
        PH_DONE_NOSEP = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_PCT  = 3'b010,
        ESC_HEX  = 3'b100
    } esc_t;

    logic [qpsd_pkg::KEY_CAP_W-1:0]   key_cap_reg;
    logic [qpsd_pkg::VALUE_CAP_W-1:0] value_cap_reg;
    phase_t                           phase_reg, phase_next;
    esc_t                             esc_reg, esc_next;
    logic [7:0]                       first_reg, first_next;
    logic [qpsd_pkg::KEY_CNT_W-1:0]   kcount_reg, kcount_next;
    logic [qpsd_pkg::VALUE_CNT_W-1:0] vcount_reg, vcount_next;
    logic                             busy_reg, busy_next;

    logic [qpsd_pkg::KEY_CAP_W-1:0]   kcap_eff;
    logic [qpsd_pkg::VALUE_CAP_W-1:0] vcap_eff;
    logic [qpsd_pkg::KEY_CNT_W-1:0]   klim;
    logic [qpsd_pkg::VALUE_CNT_W-1:0] vlim;
    logic                             accept;

    // clip and decrement the capacities
    always_comb
    begin
        kcap_eff = (key_cap_reg > qpsd_pkg::KEY_CAP_W'(qpsd_pkg::KEY_MAX)) ?
                   qpsd_pkg::KEY_CAP_W'(qpsd_pkg::KEY_MAX) : key_cap_reg;
        vcap_eff = (value_cap_reg > qpsd_pkg::VALUE_CAP_W'(qpsd_pkg::VALUE_LIMIT)) ?
                   qpsd_pkg::VALUE_CAP_W'(qpsd_pkg::VALUE_LIMIT) : value_cap_reg;
        klim = (kcap_eff == '0) ? '0 :
               qpsd_pkg::KEY_CNT_W'(kcap_eff - qpsd_pkg::KEY_CAP_W'(1));
        vlim = (vcap_eff == '0) ? '0 :
               qpsd_pkg::VALUE_CNT_W'(vcap_eff - qpsd_pkg::VALUE_CAP_W'(1));
    end

    // key bytes of the next query wait until the pending replay has read the store
    assign query_stall = cmd_full || (phase_reg == PH_KEY && busy_reg);
    assign accept      = query_valid && !query_stall;

    always_comb
    begin
        logic [7:0]      c;
        logic [1:0][7:0] vb;
        logic [1:0]      vn;
        logic            do_flush;

        c           = query_data.query_byte;
        vb          = '0;
        vn          = 2'd0;
        do_flush    = 1'b0;
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        first_next  = first_reg;
        kcount_next = kcount_reg;
        vcount_next = vcount_reg;
        busy_next   = busy_reg;
        key_wr      = '0;
        cmd_data    = '0;
        cmd_push    = 1'b0;

        if (replay_done)
            busy_next = 1'b0;

        if (accept)
        begin
            unique case (phase_reg) inside
                PH_KEY:
                begin
                    if (c == qpsd_pkg::CH_NUL)
                        phase_next = PH_DONE_NOSEP;
                    else if (c == qpsd_pkg::CH_EQ)
                    begin
                        cmd_data.key_len = kcount_reg;
                        phase_next       = PH_VALUE;
                    end
                    else if (kcount_reg < klim)
                    begin
                        key_wr.en   = 1'b1;
                        key_wr.addr = qpsd_pkg::KEY_IDX_W'(kcount_reg);
                        key_wr.data = c;
                        kcount_next = kcount_reg + qpsd_pkg::KEY_CNT_W'(1);
                    end
                end
                PH_VALUE:
                begin
                    if (c == qpsd_pkg::CH_NUL || c == qpsd_pkg::CH_AMP)
                    begin
                        do_flush   = 1'b1;
                        phase_next = PH_DONE_SEP;
                    end
                    else if (vcount_reg < vlim)
                    begin
                        vcount_next = vcount_reg + qpsd_pkg::VALUE_CNT_W'(1);
                        unique case (esc_reg)
                            ESC_NONE:
                            begin
                                if (c == qpsd_pkg::CH_PCT)
                                    esc_next = ESC_PCT;
                                else
                                begin
                                    vb[vn[0]] = qpsd_pkg::plain(c);
                                    vn        = vn + 2'd1;
                                end
                            end
                            ESC_PCT:
                            begin
                                first_next = c;
                                esc_next   = ESC_HEX;
                            end
                            ESC_HEX:
                            begin
                                vb[vn[0]]  = qpsd_pkg::hex_pair(first_reg, c);
                                vn         = vn + 2'd1;
                                esc_next   = ESC_NONE;
                                first_next = 8'd0;
                            end
                        endcase
                        // cut just filled: a pending escape goes out literally now
                        if (vcount_next >= vlim)
                            do_flush = 1'b1;
                    end
                end
                PH_DONE_SEP, PH_DONE_NOSEP:
                begin
                end
            endcase

            if (query_data.end_of_query && phase_next == PH_VALUE)
                do_flush = 1'b1;

            if (do_flush)
            begin
                unique case (esc_next)
                    ESC_NONE:
                    begin
                    end
                    ESC_PCT:
                    begin
                        vb[vn[0]] = qpsd_pkg::CH_PCT;
                        vn        = vn + 2'd1;
                    end
                    ESC_HEX:
                    begin
                        vb[vn[0]] = qpsd_pkg::CH_PCT;
                        vn        = vn + 2'd1;
                        vb[vn[0]] = qpsd_pkg::plain(first_next);
                        vn        = vn + 2'd1;
                    end
                endcase
                esc_next   = ESC_NONE;
                first_next = 8'd0;
            end

            if (query_data.end_of_query)
            begin
                cmd_data.is_end = 1'b1;
                cmd_data.sep    = (phase_next == PH_VALUE || phase_next == PH_DONE_SEP);
                phase_next      = PH_KEY;
                esc_next        = ESC_NONE;
                first_next      = 8'd0;
                kcount_next     = '0;
                vcount_next     = '0;
            end

            cmd_data.vbyte  = vb;
            cmd_data.vcount = vn;
            cmd_push = (cmd_data.key_len != '0) || (vn != 2'd0) || query_data.end_of_query;
            if (cmd_data.key_len != '0)
                busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cap_reg   <= qpsd_pkg::KEY_CAP_W'(64);
            value_cap_reg <= qpsd_pkg::VALUE_CAP_W'(256);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                qpsd_pkg::REG_KEY_CAP:   key_cap_reg   <= wr_data[qpsd_pkg::KEY_CAP_W-1:0];
                qpsd_pkg::REG_VALUE_CAP: value_cap_reg <= wr_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KEY;
            esc_reg    <= ESC_NONE;
            first_reg  <= 8'd0;
            kcount_reg <= '0;
            vcount_reg <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            first_reg  <= first_next;
            kcount_reg <= kcount_next;
            vcount_reg <= vcount_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

@@ sv/qpsd_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsd_cmd_fifo
// short command queue between the parser and the result sequencer
// ----------------------------------------------------------------------------
module qpsd_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  qpsd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output qpsd_pkg::cmd_t head,
    output logic           empty
);

    qpsd_pkg::cmd_t                  slot_reg [qpsd_pkg::CMD_DEPTH];
    logic [qpsd_pkg::CMD_PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [qpsd_pkg::CMD_CNT_W-1:0]  count_reg;
    logic                            do_push, do_pop;

    assign full    = (count_reg == qpsd_pkg::CMD_CNT_W'(qpsd_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + qpsd_pkg::CMD_PTR_W'(1);
            if (do_pop)
                rptr_reg <= rptr_reg + qpsd_pkg::CMD_PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + qpsd_pkg::CMD_CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - qpsd_pkg::CMD_CNT_W'(1);
        end
    end

endmodule

@@ sv/qpsd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsd_back
// result sequencer: key store, key replay, value bytes, end result
// ----------------------------------------------------------------------------
module qpsd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  qpsd_pkg::key_wr_t key_wr,
    input  logic              cmd_empty,
    input  qpsd_pkg::cmd_t    cmd_head,
    output logic              cmd_pop,
    output logic              replay_done,
    output logic              result_valid,
    input  logic              result_stall,
    output qpsd_pkg::result_t result_data
);

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_KEY  = 4'b0010,
        BK_VAL  = 4'b0100,
        BK_END  = 4'b1000
    } bk_state_t;

    function automatic bk_state_t first_state(input qpsd_pkg::cmd_t cmd);
        bk_state_t s;
        if (cmd.key_len != '0)
            s = BK_KEY;
        else if (cmd.vcount != 2'd0)
            s = BK_VAL;
        else
            s = BK_END;
        return s;
    endfunction

    logic [7:0]                     key_mem [qpsd_pkg::KEY_DEPTH];
    logic [7:0]                     rd_data_reg;

    bk_state_t                      state_reg, state_next;
    qpsd_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [qpsd_pkg::KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic                           vidx_reg, vidx_next;
    logic                           out_valid_reg;
    qpsd_pkg::result_t              out_reg, res;
    logic                           adv;

    // key store, read data follows the next replay index
    always_ff @(posedge clk)
    begin
        if (key_wr.en)
            key_mem[key_wr.addr] <= key_wr.data;
        rd_data_reg <= key_mem[kidx_next];
    end

    assign adv = (state_reg != BK_IDLE) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        bk_state_t follow;
        logic      finish;
        logic      load;

        follow      = state_reg;
        finish      = 1'b0;
        load        = 1'b0;
        res         = '0;
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        kidx_next   = kidx_reg;
        vidx_next   = vidx_reg;
        cmd_pop     = 1'b0;
        replay_done = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                    load = 1'b1;
            end
            BK_KEY:
            begin
                res.out_byte = rd_data_reg;
                res.part     = qpsd_pkg::PART_KEY;
                if (kidx_reg == qpsd_pkg::KEY_IDX_W'(cmd_reg.key_len - qpsd_pkg::KEY_CNT_W'(1)))
                begin
                    replay_done = adv;
                    if (cmd_reg.vcount != 2'd0)
                        follow = BK_VAL;
                    else if (cmd_reg.is_end)
                        follow = BK_END;
                    else
                        finish = 1'b1;
                end
                else if (adv)
                    kidx_next = kidx_reg + qpsd_pkg::KEY_IDX_W'(1);
            end
            BK_VAL:
            begin
                res.out_byte = cmd_reg.vbyte[vidx_reg];
                res.part     = qpsd_pkg::PART_VALUE;
                if ({1'b0, vidx_reg} == cmd_reg.vcount - 2'd1)
                begin
                    if (cmd_reg.is_end)
                        follow = BK_END;
                    else
                        finish = 1'b1;
                end
                else if (adv)
                    vidx_next = 1'b1;
            end
            BK_END:
            begin
                res.out_byte        = 8'd0;
                res.part            = qpsd_pkg::PART_END;
                res.separator_found = cmd_reg.sep;
                finish              = 1'b1;
            end
        endcase

        res.last_of_run = finish;

        if (adv)
        begin
            if (finish)
            begin
                if (!cmd_empty)
                    load = 1'b1;
                else
                    state_next = BK_IDLE;
            end
            else
                state_next = follow;
        end

        if (load)
        begin
            cmd_pop    = 1'b1;
            cmd_next   = cmd_head;
            state_next = first_state(cmd_head);
            kidx_next  = '0;
            vidx_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (adv)
            out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            kidx_reg      <= '0;
            vidx_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kidx_reg  <= kidx_next;
            vidx_reg  <= vidx_next;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule
